@@ rtl/core/isbp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isbp_pkg
// Shared types, codes and pixel classing for the bitplane packer.
// ----------------------------------------------------------------------------
package isbp_pkg;

  localparam logic [7:0] MARK_FIRST  = 8'h21;  // '!'
  localparam logic [7:0] MARK_SECOND = 8'h49;  // 'I'

  localparam logic [7:0] DEPTH_RGB888 = 8'd24;
  localparam logic [7:0] DEPTH_RGB565 = 8'd16;
  localparam logic [7:0] DEPTH_MONO   = 8'd1;
  localparam logic [7:0] DEPTH_GRAY2  = 8'd2;

  localparam logic [1:0] FMT_RGB888 = 2'd0;
  localparam logic [1:0] FMT_RGB565 = 2'd1;
  localparam logic [1:0] FMT_MONO   = 2'd2;
  localparam logic [1:0] FMT_GRAY2  = 2'd3;

  localparam logic [1:0] PIX2_WHITE = 2'b01;
  localparam logic [1:0] PIX2_COLOR = 2'b10;

  localparam logic KIND_PACKED = 1'b0;
  localparam logic KIND_ERROR  = 1'b1;

  localparam logic [7:0] CHAN_THRESH = 8'h80;
  localparam logic [7:0] ACC_INIT    = 8'hFF;
  localparam logic [7:0] BIT_LEFT    = 8'h80;

  typedef struct packed {
    logic        kind;
    logic [7:0]  mono;
    logic [7:0]  color;
    logic [15:0] row;
    logic [12:0] bcol;
    logic        rend;
    logic        fend;
  } res_t;

  typedef struct packed {
    logic load;   // take a new item into the byte register
    logic step;   // do one header byte, one RGB byte or one pixel
    logic flush;  // release the held result as the item's last one
  } dp_cmd_t;

  typedef struct packed {
    logic emit;        // current step makes a result
    logic byte_done;   // current step finishes the item
    logic pend_valid;  // a result waits in the hold register
    logic out_free;    // output register can take a result this cycle
  } dp_status_t;

  // {white, colored} for one RGB pixel
  function automatic logic [1:0] classify(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    logic rh, gh, bh;
    rh = (r > CHAN_THRESH);
    gh = (g > CHAN_THRESH);
    bh = (b > CHAN_THRESH);
    return {rh && gh && bh, rh || (gh && bh)};
  endfunction

endpackage

@@ rtl/core/isbp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isbp_ctrl
// Sequencer: takes an item, steps the datapath, releases the held result.
// ----------------------------------------------------------------------------
module isbp_ctrl import isbp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_STEP, S_FLUSH} state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        // a new result pushes the held one out, so the output must be free
        if (!(sts.emit && sts.pend_valid && !sts.out_free)) begin
          cmd.step = 1'b1;
          if (sts.byte_done) begin
            state_nxt = (sts.emit || sts.pend_valid) ? S_FLUSH : S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (!sts.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

@@ rtl/core/isbp_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isbp_dp
// Header parser, pixel classer, plane accumulators and result registers.
// ----------------------------------------------------------------------------
module isbp_dp import isbp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_data_byte,
  input  dp_cmd_t    cmd,
  output dp_status_t sts,
  input  logic       out_stall,
  output logic       out_valid,
  output res_t       out_res,
  output logic       out_last
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_MARK, PH_DEPTH, PH_WLO, PH_WHI, PH_HLO, PH_HHI, PH_PIX
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  fmt_r, fmt_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic [15:0] held_r, held_nxt;
  logic [1:0]  held_cnt_r, held_cnt_nxt;
  logic [7:0]  mono_r, mono_nxt;
  logic [7:0]  color_r, color_nxt;
  logic [7:0]  data_r;
  logic [2:0]  pix_r, pix_nxt;

  logic        pend_valid_r;
  res_t        pend_res_r;
  logic        out_valid_r;
  res_t        out_res_r;
  logic        out_last_r;

  logic        emit, byte_done, do_pack, px_white, px_col;
  res_t        res;
  logic [7:0]  mask, mono_m, color_m, sh1, sh2;
  logic [15:0] h_new, c565;
  logic        rend, fend, out_free, load_out;

  assign mask = BIT_LEFT >> col_r[2:0];
  assign rend = (({1'b0, col_r} + 17'd1) == {1'b0, width_r});
  assign fend = rend && (({1'b0, row_r} + 17'd1) == {1'b0, height_r});
  assign sh1  = data_r << pix_r;
  assign sh2  = data_r << {pix_r[1:0], 1'b0};
  assign h_new = {data_r, height_r[7:0]};
  assign c565  = {data_r, held_r[7:0]};

  always_comb begin
    phase_nxt    = phase_r;
    fmt_nxt      = fmt_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    held_nxt     = held_r;
    held_cnt_nxt = held_cnt_r;
    mono_nxt     = mono_r;
    color_nxt    = color_r;
    pix_nxt      = pix_r;
    emit         = 1'b0;
    byte_done    = 1'b1;
    res          = '0;
    do_pack      = 1'b0;
    px_white     = 1'b0;
    px_col       = 1'b0;
    mono_m       = mono_r;
    color_m      = color_r;

    case (phase_r)
      PH_HUNT: phase_nxt = (data_r == MARK_FIRST) ? PH_MARK : PH_HUNT;
      PH_MARK: phase_nxt = (data_r == MARK_SECOND) ? PH_DEPTH : PH_HUNT;
      PH_DEPTH: begin
        phase_nxt = PH_WLO;
        case (data_r)
          DEPTH_RGB888: fmt_nxt = FMT_RGB888;
          DEPTH_RGB565: fmt_nxt = FMT_RGB565;
          DEPTH_MONO:   fmt_nxt = FMT_MONO;
          DEPTH_GRAY2:  fmt_nxt = FMT_GRAY2;
          default: begin
            emit      = 1'b1;
            res.kind  = KIND_ERROR;
            phase_nxt = PH_HUNT;
          end
        endcase
      end
      PH_WLO: begin
        width_nxt = {8'h00, data_r};
        phase_nxt = PH_WHI;
      end
      PH_WHI: begin
        width_nxt = {data_r, width_r[7:0]};
        phase_nxt = PH_HLO;
      end
      PH_HLO: begin
        height_nxt = {8'h00, data_r};
        phase_nxt  = PH_HHI;
      end
      PH_HHI: begin
        height_nxt = h_new;
        if (width_r == 16'd0 || h_new == 16'd0) begin
          phase_nxt = PH_HUNT;
        end else begin
          col_nxt      = '0;
          row_nxt      = '0;
          held_nxt     = '0;
          held_cnt_nxt = '0;
          mono_nxt     = ACC_INIT;
          color_nxt    = ACC_INIT;
          phase_nxt    = PH_PIX;
        end
      end
      PH_PIX: begin
        case (fmt_r)
          FMT_RGB888: begin
            if (held_cnt_r < 2'd2) begin
              held_nxt     = (held_cnt_r == 2'd0) ? {8'h00, data_r}
                                                  : {data_r, held_r[7:0]};
              held_cnt_nxt = held_cnt_r + 2'd1;
            end else begin
              held_cnt_nxt         = '0;
              {px_white, px_col}   = classify(held_r[7:0], held_r[15:8], data_r);
              do_pack              = 1'b1;
            end
          end
          FMT_RGB565: begin
            if (held_cnt_r == 2'd0) begin
              held_nxt     = {8'h00, data_r};
              held_cnt_nxt = 2'd1;
            end else begin
              held_cnt_nxt       = '0;
              {px_white, px_col} = classify({c565[15:11], 3'b000},
                                            {c565[10:5], 2'b00},
                                            {c565[4:0], 3'b000});
              do_pack            = 1'b1;
            end
          end
          FMT_MONO: begin
            px_white = sh1[7];
            do_pack  = 1'b1;
          end
          default: begin
            px_white = (sh2[7:6] == PIX2_WHITE);
            px_col   = (sh2[7:6] == PIX2_COLOR);
            do_pack  = 1'b1;
          end
        endcase
      end
      default: phase_nxt = PH_HUNT;
    endcase

    if (do_pack) begin
      if (!px_white) begin
        if (px_col && fmt_r != FMT_MONO) begin
          color_m = color_r & ~mask;
        end else begin
          mono_m = mono_r & ~mask;
        end
      end
      if (col_r[2:0] == 3'd7 || rend) begin
        emit      = 1'b1;
        res.kind  = KIND_PACKED;
        res.mono  = mono_m;
        res.color = color_m;
        res.row   = row_r;
        res.bcol  = col_r[15:3];
        res.rend  = rend;
        res.fend  = fend;
        mono_nxt  = ACC_INIT;
        color_nxt = ACC_INIT;
      end else begin
        mono_nxt  = mono_m;
        color_nxt = color_m;
      end
      col_nxt = col_r + 16'd1;
      if (rend) begin
        col_nxt = '0;
        row_nxt = row_r + 16'd1;
      end
      if (fend) begin
        phase_nxt = PH_HUNT;
      end
      // sub-byte formats walk the pixels of the item one per step
      if (fmt_r == FMT_MONO) begin
        byte_done = (pix_r == 3'd7) || fend;
      end else if (fmt_r == FMT_GRAY2) begin
        byte_done = (pix_r == 3'd3) || fend;
      end
      pix_nxt = byte_done ? 3'd0 : pix_r + 3'd1;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (cmd.step && emit && pend_valid_r) || cmd.flush;

  assign sts.emit       = emit;
  assign sts.byte_done  = byte_done;
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      fmt_r        <= FMT_RGB888;
      width_r      <= '0;
      height_r     <= '0;
      col_r        <= '0;
      row_r        <= '0;
      held_r       <= '0;
      held_cnt_r   <= '0;
      mono_r       <= ACC_INIT;
      color_r      <= ACC_INIT;
      pix_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        pix_r <= '0;
      end
      if (cmd.step) begin
        phase_r    <= phase_nxt;
        fmt_r      <= fmt_nxt;
        width_r    <= width_nxt;
        height_r   <= height_nxt;
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        held_r     <= held_nxt;
        held_cnt_r <= held_cnt_nxt;
        mono_r     <= mono_nxt;
        color_r    <= color_nxt;
        pix_r      <= pix_nxt;
        if (emit) begin
          pend_valid_r <= 1'b1;
        end
      end
      if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_r <= in_data_byte;
    end
    if (load_out) begin
      out_res_r  <= pend_res_r;
      out_last_r <= cmd.flush;
    end
    if (cmd.step && emit) begin
      pend_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

endmodule

@@ rtl/core/image_stream_to_bitplane_packer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_stream_to_bitplane_packer_unit
// Parses a byte stream image transfer and packs black and color bitplanes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data_byte) takes one stream byte
//   per item. Output channel (out_valid / out_stall / out_*) returns packed
//   plane byte pairs with row, byte column and end flags, or an error item
//   for an unsupported color depth. out_last marks the final result that an
//   input item causes; items that cause no result produce nothing.
// Flow:
//   Each item is loaded into the byte register, then worked one step per
//   cycle unless a result must wait for the output: one step per header
//   byte or RGB byte, one per pixel for 1-bit (8 pixels) and 2-bit (4 pixels)
//   bytes. Results go through a one-entry hold register so the last flag is
//   known; an item that produced results ends by releasing the held one.
//   A new item is taken only once the last one is worked and released.
//   The pixel sequencer is the limit; sub-byte pixels go one per step.
//   Results show in the cycle after release into the output register.
// Reset: rst_n (synchronous, active low) returns to the marker hunt with the
//   plane accumulators set to all ones and the output empty.
// Stall: out_stall holds the output register; the sequencer waits when a new
//   result would displace the held one, or the held one cannot be released, and in_stall stays high.
// ----------------------------------------------------------------------------
module image_stream_to_bitplane_packer_unit import isbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_mono_byte,
  output logic [7:0]  out_chroma_byte,
  output logic [15:0] out_row,
  output logic [12:0] out_byte_column,
  output logic        out_row_end,
  output logic        out_frame_end,
  output logic        out_last
);

  dp_cmd_t    cmd;
  dp_status_t sts;
  res_t       res;

  // sequencer: load, step, release
  isbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // header registers, pixel classer, accumulators, hold and output registers
  isbp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data_byte (in_data_byte),
    .cmd          (cmd),
    .sts          (sts),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_res      (res),
    .out_last     (out_last)
  );

  assign out_kind        = res.kind;
  assign out_mono_byte   = res.mono;
  assign out_chroma_byte = res.color;
  assign out_row         = res.row;
  assign out_byte_column = res.bcol;
  assign out_row_end     = res.rend;
  assign out_frame_end   = res.fend;

endmodule
